// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define QMPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qmpc assertion failed");

// Next-cycle implication.
`define QMPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qmpc assertion failed");

`endif

// ===== src/qmpc_pkg.sv =====
// Package: types and constants of the quad motor PWM controller.
`timescale 1ns / 1ps
package qmpc_pkg;

    localparam int QMPC_MOTOR_COUNT   = 4;
    localparam int QMPC_COUNTER_WIDTH = 8;

    localparam int DUTY_W   = 16;
    localparam int THR_W    = 17;
    localparam int OUT_CH   = 4;
    localparam int IDX_W    = 8;
    localparam int PRE_W    = 3;
    localparam int TOP_W    = 8;
    localparam int CFG_AW   = 2;

    localparam logic [DUTY_W-1:0] Q_ONE        = 16'd32768;
    localparam logic [DUTY_W-1:0] PULSE_LO_RST = 16'd0;
    localparam logic [DUTY_W-1:0] PULSE_HI_RST = 16'd255;

    localparam logic [PRE_W-1:0] PRE_LIMIT_FAST = 3'd0;
    localparam logic [PRE_W-1:0] PRE_LIMIT_SLOW = 3'd6;
    localparam logic [TOP_W-1:0] TOP_FAST       = 8'd255;
    localparam logic [TOP_W-1:0] TOP_SLOW       = 8'd239;

    localparam logic [CFG_AW-1:0] CFG_PULSE_LO  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PULSE_HI  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_FREQ_MODE = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_SET_ALL = 3'd1,
        OP_SET_ONE = 3'd2,
        OP_SET_RAW = 3'd3,
        OP_ARM     = 3'd4,
        OP_DISARM  = 3'd5,
        OP_STOP    = 3'd6,
        OP_ESTOP   = 3'd7
    } t_op;

    typedef struct packed {
        logic accept;
        logic load_thr;
        logic load_raw;
        logic clear;
        logic wrap;
    } t_lane_ctl;

endpackage

// ===== src/quad_motor_pwm_controller.sv =====
// Top level of the quad motor PWM controller.
`timescale 1ns / 1ps
// Each accepted item is one timer tick plus an optional command; the block takes one
// item every clock cycle and returns exactly one result per item from an output
// register in the next cycle, so the input stalls only while that register holds a
// result the sink has not taken. Each channel lane maps its throttle with one
// 16x16 multiplier and an adder, combinationally; the shared counter advances
// only on accepted items while armed. Commanded compare values become active when
// the period counter wraps (every 256 ticks with freq_mode 0, every 1680 with 1).
`include "assert_macros.svh"
module quad_motor_pwm_controller #(
    parameter int MOTOR_COUNT   = qmpc_pkg::QMPC_MOTOR_COUNT,
    parameter int COUNTER_WIDTH = qmpc_pkg::QMPC_COUNTER_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qmpc_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [qmpc_pkg::DUTY_W-1:0]   i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // motor_index, throttle_a, throttle_b, throttle_c, throttle_d, raw_ratio, zero pad
    input  logic [95:0]                   i_s_axis_tdata,
    // op
    input  logic [2:0]                    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // pin_one..pin_four, is_armed, duty_one..duty_four, zero pad
    output logic [71:0]                   o_m_axis_tdata
);
    import qmpc_pkg::*;

    logic [DUTY_W-1:0] r_pulse_lo, r_pulse_hi;
    logic              r_freq_mode;
    logic              r_armed, n_armed;
    logic              r_out_valid;
    logic [71:0]       r_out_data;

    logic              w_accept;
    t_op               w_op;
    logic [IDX_W-1:0]  w_idx;
    logic signed [THR_W-1:0] w_thr_in [OUT_CH];
    logic [DUTY_W-1:0] w_raw;
    logic [DUTY_W-1:0] w_range;
    logic              w_clear;
    logic              w_adv;
    logic              w_wrap;
    logic [COUNTER_WIDTH-1:0] w_period;
    logic [PRE_W-1:0]  w_prescale;
    logic [DUTY_W-1:0] w_duty [MOTOR_COUNT];
    logic              w_pin  [MOTOR_COUNT];
    logic [DUTY_W-1:0] w_duty_o [OUT_CH];
    logic              w_pin_o  [OUT_CH];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_op        = t_op'(i_s_axis_tuser);
    assign w_idx       = i_s_axis_tdata[7:0];
    assign w_thr_in[0] = i_s_axis_tdata[24:8];
    assign w_thr_in[1] = i_s_axis_tdata[41:25];
    assign w_thr_in[2] = i_s_axis_tdata[58:42];
    assign w_thr_in[3] = i_s_axis_tdata[75:59];
    assign w_raw       = i_s_axis_tdata[91:76];
    assign w_range     = r_pulse_hi - r_pulse_lo;

    always_comb begin
        n_armed = r_armed;
        w_clear = 1'b0;
        case (w_op)
            OP_ARM: begin
                n_armed = 1'b1;
                w_clear = !r_armed;
            end
            OP_DISARM: begin
                n_armed = 1'b0;
                w_clear = r_armed;
            end
            OP_STOP: begin
                w_clear = r_armed;
            end
            OP_ESTOP: begin
                n_armed = 1'b0;
                w_clear = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_adv = w_accept && n_armed;

    qmpc_timebase #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_timebase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_freq_mode (r_freq_mode),
        .o_period    (w_period),
        .o_prescale  (w_prescale),
        .o_wrap      (w_wrap)
    );

    for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_lane
        t_lane_ctl               w_ctl;
        logic signed [THR_W-1:0] w_thr;
        logic                    w_sel;

        if (g < OUT_CH) begin : g_thr
            assign w_thr = (w_op == OP_SET_ONE) ? w_thr_in[0] : w_thr_in[g];
        end else begin : g_thr_zero
            assign w_thr = (w_op == OP_SET_ONE) ? w_thr_in[0] : '0;
        end

        assign w_sel          = (w_idx == IDX_W'(g));
        assign w_ctl.accept   = w_accept;
        assign w_ctl.load_thr = r_armed &&
                                ((w_op == OP_SET_ALL) || ((w_op == OP_SET_ONE) && w_sel));
        assign w_ctl.load_raw = r_armed && (w_op == OP_SET_RAW) && w_sel;
        assign w_ctl.clear    = w_clear;
        assign w_ctl.wrap     = w_wrap;

        qmpc_lane #(
            .COUNTER_WIDTH (COUNTER_WIDTH)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_throttle  (w_thr),
            .i_raw       (w_raw),
            .i_pulse_lo  (r_pulse_lo),
            .i_range     (w_range),
            .i_armed     (n_armed),
            .i_period    (w_period),
            .o_duty      (w_duty[g]),
            .o_pin       (w_pin[g])
        );
    end

    for (genvar c = 0; c < OUT_CH; c++) begin : g_out
        if (c < MOTOR_COUNT) begin : g_used
            assign w_duty_o[c] = w_duty[c];
            assign w_pin_o[c]  = w_pin[c];
        end else begin : g_unused
            assign w_duty_o[c] = '0;
            assign w_pin_o[c]  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_lo  <= PULSE_LO_RST;
            r_pulse_hi  <= PULSE_HI_RST;
            r_freq_mode <= 1'b0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PULSE_LO:  r_pulse_lo  <= i_cfg_wdata;
                    CFG_PULSE_HI:  r_pulse_hi  <= i_cfg_wdata;
                    CFG_FREQ_MODE: r_freq_mode <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_armed     <= n_armed;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {3'b000, w_duty_o[3], w_duty_o[2], w_duty_o[1], w_duty_o[0],
                           n_armed, w_pin_o[3], w_pin_o[2], w_pin_o[1], w_pin_o[0]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `QMPC_ASSERT_NOW(a_pins_low_disarmed, o_m_axis_tvalid && !o_m_axis_tdata[4], o_m_axis_tdata[3:0] == 4'b0000)
    `QMPC_ASSERT_NEXT(a_estop_disarms, w_accept && (w_op == OP_ESTOP), !r_armed)
    `QMPC_ASSERT_NEXT(a_hold_disarmed, !w_adv, $stable(w_period) && $stable(w_prescale))
    `QMPC_ASSERT_NOW(a_prescale_range, 1'b1, w_prescale <= PRE_LIMIT_SLOW)

endmodule

// ===== src/qmpc_timebase.sv =====
// Prescaler and period counter shared by all channels.
`timescale 1ns / 1ps
module qmpc_timebase #(
    parameter int COUNTER_WIDTH = qmpc_pkg::QMPC_COUNTER_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_freq_mode,
    output logic [COUNTER_WIDTH-1:0] o_period,
    output logic [qmpc_pkg::PRE_W-1:0] o_prescale,
    output logic                     o_wrap
);
    import qmpc_pkg::*;

    logic [PRE_W-1:0]         r_prescale, n_prescale;
    logic [COUNTER_WIDTH-1:0] r_period, n_period;
    logic [PRE_W-1:0]         w_limit;
    logic [COUNTER_WIDTH-1:0] w_top;
    logic                     w_pre_done;

    assign w_limit    = i_freq_mode ? PRE_LIMIT_SLOW : PRE_LIMIT_FAST;
    assign w_top      = COUNTER_WIDTH'(i_freq_mode ? TOP_SLOW : TOP_FAST);
    assign w_pre_done = (r_prescale >= w_limit);
    assign o_wrap     = i_adv && w_pre_done && (r_period >= w_top);

    always_comb begin
        n_prescale = r_prescale;
        n_period   = r_period;
        if (i_adv) begin
            if (!w_pre_done) begin
                n_prescale = r_prescale + 1'b1;
            end else begin
                n_prescale = '0;
                if (r_period >= w_top) begin
                    n_period = '0;
                end else begin
                    n_period = r_period + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_period   <= '0;
        end else begin
            r_prescale <= n_prescale;
            r_period   <= n_period;
        end
    end

    assign o_period   = r_period;
    assign o_prescale = r_prescale;

endmodule

// ===== src/qmpc_lane.sv =====
// One PWM channel: throttle mapping, preload and active compare, pin level.
`timescale 1ns / 1ps
module qmpc_lane #(
    parameter int COUNTER_WIDTH = qmpc_pkg::QMPC_COUNTER_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  qmpc_pkg::t_lane_ctl                 i_ctl,
    input  logic signed [qmpc_pkg::THR_W-1:0]   i_throttle,
    input  logic [qmpc_pkg::DUTY_W-1:0]         i_raw,
    input  logic [qmpc_pkg::DUTY_W-1:0]         i_pulse_lo,
    input  logic [qmpc_pkg::DUTY_W-1:0]         i_range,
    input  logic                                i_armed,
    input  logic [COUNTER_WIDTH-1:0]            i_period,
    output logic [qmpc_pkg::DUTY_W-1:0]         o_duty,
    output logic                                o_pin
);
    import qmpc_pkg::*;

    logic [DUTY_W-1:0]   r_preload, n_preload;
    logic [DUTY_W-1:0]   r_active;
    logic [DUTY_W-1:0]   w_thr;
    logic [2*DUTY_W-1:0] w_prod;
    logic [DUTY_W-1:0]   w_cmp;

    always_comb begin
        if (i_throttle[THR_W-1]) begin
            w_thr = '0;
        end else if (i_throttle[DUTY_W-1:0] > Q_ONE) begin
            w_thr = Q_ONE;
        end else begin
            w_thr = i_throttle[DUTY_W-1:0];
        end
    end

    // t is at most 2^15, so the product stays below 2^31
    assign w_prod = (2*DUTY_W)'(w_thr) * (2*DUTY_W)'(i_range);
    assign w_cmp  = i_pulse_lo + w_prod[DUTY_W+14:15];

    always_comb begin
        n_preload = r_preload;
        if (i_ctl.clear) begin
            n_preload = '0;
        end else if (i_ctl.load_thr) begin
            n_preload = w_cmp;
        end else if (i_ctl.load_raw) begin
            n_preload = i_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preload <= '0;
            r_active  <= '0;
        end else if (i_ctl.accept) begin
            r_preload <= n_preload;
            if (i_ctl.wrap) begin
                r_active <= n_preload;
            end
        end
    end

    assign o_duty = n_preload;
    assign o_pin  = i_armed && (DUTY_W'(i_period) < r_active);

endmodule

// ===== sim/quad_motor_pwm_controller_test.sv =====
// Testbench for the quad motor PWM controller: command stream, PWM scoreboard, random stalls.
`timescale 1ns / 1ps

class pwm_scoreboard;
    logic [15:0] pulse_lo;
    logic [15:0] pulse_hi;
    logic        freq_mode;
    logic        armed;
    logic [15:0] duty_next[4];
    logic [15:0] duty_live[4];
    logic [2:0]  pre_cnt;
    logic [7:0]  per_cnt;
    logic [71:0] frames_due[$];
    int          errors;

    function new();
        pulse_lo  = qmpc_pkg::PULSE_LO_RST;
        pulse_hi  = qmpc_pkg::PULSE_HI_RST;
        freq_mode = 1'b0;
        armed     = 1'b0;
        pre_cnt   = '0;
        per_cnt   = '0;
        errors    = 0;
        for (int i = 0; i < 4; i++) begin
            duty_next[i] = '0;
            duty_live[i] = '0;
        end
    endfunction

    function void write_reg(logic [1:0] addr, logic [15:0] data);
        case (addr)
            qmpc_pkg::CFG_PULSE_LO:  pulse_lo  = data;
            qmpc_pkg::CFG_PULSE_HI:  pulse_hi  = data;
            qmpc_pkg::CFG_FREQ_MODE: freq_mode = data[0];
            default: ;
        endcase
    endfunction

    function logic [15:0] throttle_compare(logic [16:0] thr);
        logic [16:0] t;
        logic [15:0] span;
        logic [31:0] prod;
        if (thr[16])
            t = '0;
        else if (thr > 17'd32768)
            t = 17'd32768;
        else
            t = thr;
        span = pulse_hi - pulse_lo;
        prod = {16'b0, t[15:0]} * {16'b0, span};
        return pulse_lo + prod[30:15];
    endfunction

    function void clear_next();
        for (int i = 0; i < 4; i++) duty_next[i] = '0;
    endfunction

    function void advance();
        logic [2:0] pre_limit;
        logic [7:0] top;
        pre_limit = freq_mode ? qmpc_pkg::PRE_LIMIT_SLOW : qmpc_pkg::PRE_LIMIT_FAST;
        top       = freq_mode ? qmpc_pkg::TOP_SLOW : qmpc_pkg::TOP_FAST;
        if (pre_cnt < pre_limit) begin
            pre_cnt = pre_cnt + 3'd1;
            return;
        end
        pre_cnt = '0;
        if (per_cnt >= top) begin
            per_cnt = '0;
            for (int i = 0; i < 4; i++) duty_live[i] = duty_next[i];
        end else begin
            per_cnt = per_cnt + 8'd1;
        end
    endfunction

    function void note_item(logic [2:0] user, logic [95:0] data);
        qmpc_pkg::t_op op;
        logic [7:0]    idx;
        logic [16:0]   thr[4];
        logic [15:0]   raw;
        logic [71:0]   frame;
        op  = qmpc_pkg::t_op'(user);
        idx = data[7:0];
        for (int i = 0; i < 4; i++) thr[i] = data[8 + 17*i +: 17];
        raw = data[76 +: 16];
        case (op)
            qmpc_pkg::OP_SET_ALL: begin
                if (armed)
                    for (int i = 0; i < 4; i++) duty_next[i] = throttle_compare(thr[i]);
            end
            qmpc_pkg::OP_SET_ONE: begin
                if (armed && idx < qmpc_pkg::QMPC_MOTOR_COUNT)
                    duty_next[idx[1:0]] = throttle_compare(thr[0]);
            end
            qmpc_pkg::OP_SET_RAW: begin
                if (armed && idx < qmpc_pkg::QMPC_MOTOR_COUNT)
                    duty_next[idx[1:0]] = raw;
            end
            qmpc_pkg::OP_ARM: begin
                if (!armed) begin
                    clear_next();
                    armed = 1'b1;
                end
            end
            qmpc_pkg::OP_DISARM, qmpc_pkg::OP_STOP, qmpc_pkg::OP_ESTOP: begin
                if (armed || op == qmpc_pkg::OP_ESTOP) begin
                    clear_next();
                    if (op != qmpc_pkg::OP_STOP) armed = 1'b0;
                end
            end
            default: ;
        endcase
        frame = '0;
        for (int i = 0; i < 4; i++) begin
            frame[i]            = armed && ({8'b0, per_cnt} < duty_live[i]);
            frame[5 + 16*i +: 16] = duty_next[i];
        end
        frame[4] = armed;
        frames_due.push_back(frame);
        if (armed) advance();
    endfunction

    function void check_result(logic [71:0] got);
        logic [71:0] want;
        if (frames_due.size() == 0) begin
            $display("%0t: result with none due, expected nothing, got %h", $time, got);
            errors++;
            return;
        end
        want = frames_due.pop_front();
        for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
                $display("%0t: pin %0d expected %b got %b", $time, i, want[i], got[i]);
                errors++;
            end
        end
        if (got[4] !== want[4]) begin
            $display("%0t: armed expected %b got %b", $time, want[4], got[4]);
            errors++;
        end
        for (int i = 0; i < 4; i++) begin
            if (got[5 + 16*i +: 16] !== want[5 + 16*i +: 16]) begin
                $display("%0t: duty %0d expected %h got %h", $time, i,
                         want[5 + 16*i +: 16], got[5 + 16*i +: 16]);
                errors++;
            end
        end
    endfunction

    function int pending_count();
        return frames_due.size();
    endfunction
endclass

module quad_motor_pwm_controller_test;
    import qmpc_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [95:0] s_data    = '0;
    logic [2:0]  s_user    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [71:0] m_data;

    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit armed_guess = 1'b0;
    int rx_hold     = 0;
    int quiet       = 0;

    pwm_scoreboard sb;

    quad_motor_pwm_controller u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) sb.write_reg(cfg_addr, cfg_wdata);
            if (s_valid && s_ready) sb.note_item(s_user, s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // sink side: random hold-off after each taken result
    always @(posedge clk) begin
        if (m_ready && m_valid) begin
            rx_hold = rx_idle_on ? $urandom_range(0, 19) : 0;
            if (rx_hold != 0) m_ready <= 1'b0;
        end else if (!m_ready && rst_n) begin
            if (rx_hold > 0) rx_hold = rx_hold - 1;
            if (rx_hold == 0) m_ready <= 1'b1;
        end
    end

    initial begin
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic logic [16:0] pick_throttle();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 17'h10000;
            1: return 17'h0FFFF;
            2: return 17'd32768;
            3: return 17'd0;
            4, 5: return 17'($urandom);
            default: return 17'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [15:0] pick_raw();
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 300));
    endfunction

    task automatic drive_command(t_op op, logic [7:0] idx, logic [16:0] t0, logic [16:0] t1,
                                 logic [16:0] t2, logic [16:0] t3, logic [15:0] raw);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {4'b0, raw, t3, t2, t1, t0, idx};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        case (op)
            OP_ARM: armed_guess = 1'b1;
            OP_DISARM, OP_ESTOP: armed_guess = 1'b0;
            default: ;
        endcase
    endtask

    task automatic random_command();
        t_op op;
        int  r;
        r = $urandom_range(0, 99);
        if (!armed_guess && r < 70) begin
            op = OP_ARM;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 45)      op = OP_TICK;
            else if (r < 63) op = OP_SET_ALL;
            else if (r < 76) op = OP_SET_ONE;
            else if (r < 90) op = OP_SET_RAW;
            else if (r < 93) op = OP_ARM;
            else if (r < 95) op = OP_DISARM;
            else if (r < 98) op = OP_STOP;
            else             op = OP_ESTOP;
        end
        drive_command(op, pick_index(), pick_throttle(), pick_throttle(), pick_throttle(),
                      pick_throttle(), pick_raw());
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_count() != 0) @(posedge clk);
    endtask

    task automatic program_rates(logic [15:0] lo, logic [15:0] hi, logic fm);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_PULSE_LO;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_addr  <= CFG_PULSE_HI;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_addr  <= CFG_FREQ_MODE;
        cfg_wdata <= {15'b0, fm};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disarmed: everything but arm and emergency stop is dropped
        drive_command(OP_TICK, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_SET_ALL, 8'd255, 17'd32768, 17'd32768, 17'd32768, 17'd32768, 16'hFFFF);
        drive_command(OP_SET_ONE, 8'd0, 17'd32768, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_SET_RAW, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'hFFFF);
        drive_command(OP_DISARM, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_STOP, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_ESTOP, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_ARM, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_ARM, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        // clamp at both ends, then out-of-range indices, raw loads, stop, disarm and emergency stop
        drive_command(OP_SET_ALL, 8'd0, 17'd32768, 17'h10000, 17'h0FFFF, 17'd0, 16'd0);
        drive_command(OP_SET_ALL, 8'd0, 17'h1FFFF, 17'd16384, 17'd1, 17'd32767, 16'd0);
        drive_command(OP_SET_ONE, 8'd3, 17'd16384, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_SET_ONE, 8'd4, 17'd32768, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_SET_ONE, 8'd255, 17'd32768, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_SET_RAW, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'hFFFF);
        drive_command(OP_SET_RAW, 8'd1, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_SET_RAW, 8'd2, 17'd0, 17'd0, 17'd0, 17'd0, 16'd200);
        drive_command(OP_SET_RAW, 8'd128, 17'd0, 17'd0, 17'd0, 17'd0, 16'd12345);
        drive_command(OP_STOP, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_SET_ONE, 8'd1, 17'h0FFFF, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_TICK, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_DISARM, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_TICK, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_ARM, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drive_command(OP_ESTOP, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0);
        drain();

        // park the period counter above 239, then switch to the slow rate
        drive_command(OP_ARM, pick_index(), pick_throttle(), pick_throttle(), pick_throttle(),
                      pick_throttle(), pick_raw());
        for (int i = 0; i < 4; i++)
            drive_command(OP_SET_RAW, 8'(i), pick_throttle(), pick_throttle(), pick_throttle(),
                          pick_throttle(), 16'($urandom_range(1, 300)));
        repeat (240)
            drive_command(OP_TICK, pick_index(), pick_throttle(), pick_throttle(),
                          pick_throttle(), pick_throttle(), pick_raw());
        drive_command(OP_DISARM, pick_index(), pick_throttle(), pick_throttle(), pick_throttle(),
                      pick_throttle(), pick_raw());
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: program_rates(16'd1000, 16'd2000, 1'b1);
                1: program_rates(16'd0, 16'hFFFF, 1'b0);
                2: program_rates(16'hFFFF, 16'd0, 1'b1);
                3: program_rates(16'd0, 16'd0, 1'b0);
                4: program_rates(16'hFFFF, 16'hFFFF, 1'b0);
                default: program_rates(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
            endcase
            tx_idle_on = (p != 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on <= (p != 1) && ($urandom_range(0, 3) != 0);
            if (p == 0) begin
                drive_command(OP_ARM, pick_index(), pick_throttle(), pick_throttle(),
                              pick_throttle(), pick_throttle(), pick_raw());
                for (int i = 0; i < 4; i++)
                    drive_command(OP_SET_RAW, 8'(i), pick_throttle(), pick_throttle(),
                                  pick_throttle(), pick_throttle(), 16'($urandom_range(1, 300)));
            end
            repeat (210) random_command();
            drain();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/qmpc_pkg.sv
src/qmpc_timebase.sv
src/qmpc_lane.sv
src/quad_motor_pwm_controller.sv
sim/quad_motor_pwm_controller_test.sv
